>>> rtl/core/segi_pkg.sv
// ----------------------------------------------------------------------------
// segi_pkg
// Shared types, codes and defaults of the segment intersection pipeline.
// ----------------------------------------------------------------------------
package segi_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int ALPHA_BITS_DEF = 32;

   localparam int DET_MIN_W = 63;
   localparam int MARGIN_W  = 31;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 63;

   localparam logic [DET_MIN_W-1:0] DET_MIN_RST = 63'd1;
   localparam logic [MARGIN_W-1:0]  MARGIN_RST  = 31'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_DET_MIN      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_MARGIN = 1'b1;

   localparam logic [1:0] ST_HIT      = 2'd0;
   localparam logic [1:0] ST_PARALLEL = 2'd1;
   localparam logic [1:0] ST_MISS     = 2'd2;

   typedef struct packed {
      logic signed [31:0] p1_x;
      logic signed [31:0] p1_y;
      logic signed [31:0] p2_x;
      logic signed [31:0] p2_y;
      logic signed [31:0] q1_x;
      logic signed [31:0] q1_y;
      logic signed [31:0] q2_x;
      logic signed [31:0] q2_y;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
      logic [31:0]        alpha_p;
      logic [31:0]        alpha_q;
   } rsp_word_type;

endpackage

>>> rtl/core/segi_div.sv
// ----------------------------------------------------------------------------
// segi_div
// Pipelined restoring divider, one quotient bit per stage, two numerators
// over a shared denominator, with a side tag carried along.
// ----------------------------------------------------------------------------
module segi_div import segi_pkg::*; #(
   parameter int XW = 67,
   parameter int AB = ALPHA_BITS_DEF,
   parameter int TW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [XW-1:0] in_num_p,
   input  logic [XW-1:0] in_num_q,
   input  logic [XW-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [AB-1:0] out_quo_p,
   output logic [AB-1:0] out_quo_q,
   output logic [TW-1:0] out_tag
);

   logic          vld_ff   [0:AB];
   logic [XW-1:0] rem_p_ff [0:AB];
   logic [XW-1:0] rem_q_ff [0:AB];
   logic [XW-1:0] den_ff   [0:AB];
   logic [AB-1:0] quo_p_ff [0:AB];
   logic [AB-1:0] quo_q_ff [0:AB];
   logic [TW-1:0] tag_ff   [0:AB];

   logic [XW-1:0] rem_p_in [1:AB];
   logic [XW-1:0] rem_q_in [1:AB];
   logic          bit_p_in [1:AB];
   logic          bit_q_in [1:AB];

   // remainder is XW bits wide, so the shifted value fits one more bit
   always_comb begin
      logic [XW:0] sp;
      logic [XW:0] sq;
      for (int k = 1; k <= AB; k++) begin
         sp = {rem_p_ff[k-1], 1'b0};
         sq = {rem_q_ff[k-1], 1'b0};
         bit_p_in[k] = (sp >= {1'b0, den_ff[k-1]});
         bit_q_in[k] = (sq >= {1'b0, den_ff[k-1]});
         rem_p_in[k] = bit_p_in[k] ? XW'(sp - {1'b0, den_ff[k-1]}) : XW'(sp);
         rem_q_in[k] = bit_q_in[k] ? XW'(sq - {1'b0, den_ff[k-1]}) : XW'(sq);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= AB; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= AB; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_p_ff[0] <= in_num_p;
         rem_q_ff[0] <= in_num_q;
         den_ff[0]   <= in_den;
         quo_p_ff[0] <= '0;
         quo_q_ff[0] <= '0;
         tag_ff[0]   <= in_tag;
         for (int k = 1; k <= AB; k++) begin
            rem_p_ff[k] <= rem_p_in[k];
            rem_q_ff[k] <= rem_q_in[k];
            den_ff[k]   <= den_ff[k-1];
            quo_p_ff[k] <= {quo_p_ff[k-1][AB-2:0], bit_p_in[k]};
            quo_q_ff[k] <= {quo_q_ff[k-1][AB-2:0], bit_q_in[k]};
            tag_ff[k]   <= tag_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[AB];
   assign out_quo_p = quo_p_ff[AB];
   assign out_quo_q = quo_q_ff[AB];
   assign out_tag   = tag_ff[AB];

endmodule

>>> rtl/core/segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_intersection
// Parametric intersection of two segments in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one segment pair per cycle unless stalled and returns one word per pair,
// in order, through a restoring divider with one quotient bit per stage.
// The whole pipeline stalls while a finished word waits on rsp_ready.
// Configuration registers may be written only while the pipeline is empty.
module segment_intersection import segi_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int ALPHA_BITS = ALPHA_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_word_type         req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_word_type         rsp_word,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int CB  = COORD_BITS;
   localparam int AB  = ALPHA_BITS;
   localparam int DW  = CB + 1;
   localparam int PW  = 2 * DW;
   localparam int XW  = PW + 1;
   localparam int TW  = 2 * CB + 2 * DW + 3;
   localparam int MW  = AB + 1 + DW;

   logic [DET_MIN_W-1:0] det_min_ff;
   logic [MARGIN_W-1:0]  margin_ff;
   logic                 en;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         det_min_ff <= DET_MIN_RST;
         margin_ff  <= MARGIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DET_MIN:      det_min_ff <= csr_wdata[DET_MIN_W-1:0];
            CSR_ALPHA_MARGIN: margin_ff  <= csr_wdata[MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: direction and offset vectors
   logic                 v1_ff;
   logic signed [CB-1:0] px_ff, py_ff;
   logic signed [DW-1:0] rx_ff, ry_ff, sx_ff, sy_ff, wx_ff, wy_ff;
   logic signed [DW-1:0] p1x_in, p1y_in, p2x_in, p2y_in, q1x_in, q1y_in, q2x_in, q2y_in;

   assign p1x_in = DW'(signed'(req_word.p1_x[CB-1:0]));
   assign p1y_in = DW'(signed'(req_word.p1_y[CB-1:0]));
   assign p2x_in = DW'(signed'(req_word.p2_x[CB-1:0]));
   assign p2y_in = DW'(signed'(req_word.p2_y[CB-1:0]));
   assign q1x_in = DW'(signed'(req_word.q1_x[CB-1:0]));
   assign q1y_in = DW'(signed'(req_word.q1_y[CB-1:0]));
   assign q2x_in = DW'(signed'(req_word.q2_x[CB-1:0]));
   assign q2y_in = DW'(signed'(req_word.q2_y[CB-1:0]));

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= req_word.p1_x[CB-1:0];
         py_ff <= req_word.p1_y[CB-1:0];
         rx_ff <= p2x_in - p1x_in;
         ry_ff <= p2y_in - p1y_in;
         sx_ff <= q2x_in - q1x_in;
         sy_ff <= q2y_in - q1y_in;
         wx_ff <= q1x_in - p1x_in;
         wy_ff <= q1y_in - p1y_in;
      end
   end

   // stage 2: six products
   logic                 v2_ff;
   logic signed [CB-1:0] px2_ff, py2_ff;
   logic signed [DW-1:0] rx2_ff, ry2_ff;
   logic signed [PW-1:0] m_rs_ff, m_sr_ff, m_ws_ff, m_sw_ff, m_wr_ff, m_rw_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px2_ff  <= px_ff;
         py2_ff  <= py_ff;
         rx2_ff  <= rx_ff;
         ry2_ff  <= ry_ff;
         m_rs_ff <= PW'(rx_ff) * PW'(sy_ff);
         m_sr_ff <= PW'(ry_ff) * PW'(sx_ff);
         m_ws_ff <= PW'(wx_ff) * PW'(sy_ff);
         m_sw_ff <= PW'(wy_ff) * PW'(sx_ff);
         m_wr_ff <= PW'(wx_ff) * PW'(ry_ff);
         m_rw_ff <= PW'(wy_ff) * PW'(rx_ff);
      end
   end

   // stage 3: cross products
   logic                 v3_ff;
   logic signed [CB-1:0] px3_ff, py3_ff;
   logic signed [DW-1:0] rx3_ff, ry3_ff;
   logic signed [XW-1:0] det_ff, nump_ff, numq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px3_ff  <= px2_ff;
         py3_ff  <= py2_ff;
         rx3_ff  <= rx2_ff;
         ry3_ff  <= ry2_ff;
         det_ff  <= XW'(m_rs_ff) - XW'(m_sr_ff);
         nump_ff <= XW'(m_ws_ff) - XW'(m_sw_ff);
         numq_ff <= XW'(m_wr_ff) - XW'(m_rw_ff);
      end
   end

   // stage 4: magnitudes and sign tests
   logic                 v4_ff;
   logic signed [CB-1:0] px4_ff, py4_ff;
   logic signed [DW-1:0] rx4_ff, ry4_ff;
   logic [XW-1:0]        adet_ff, anp_ff, anq_ff;
   logic                 dzero_ff, sgn_ok_p_ff, sgn_ok_q_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px4_ff      <= px3_ff;
         py4_ff      <= py3_ff;
         rx4_ff      <= rx3_ff;
         ry4_ff      <= ry3_ff;
         adet_ff     <= det_ff[XW-1]  ? XW'(-det_ff)  : XW'(det_ff);
         anp_ff      <= nump_ff[XW-1] ? XW'(-nump_ff) : XW'(nump_ff);
         anq_ff      <= numq_ff[XW-1] ? XW'(-numq_ff) : XW'(numq_ff);
         dzero_ff    <= (det_ff == '0);
         sgn_ok_p_ff <= (nump_ff != '0) && (nump_ff[XW-1] == det_ff[XW-1]);
         sgn_ok_q_ff <= (numq_ff != '0) && (numq_ff[XW-1] == det_ff[XW-1]);
      end
   end

   // stage 5: parallel test and proper-fraction test
   logic                 v5_ff;
   logic [TW-1:0]        tag5_ff;
   logic [XW-1:0]        adet5_ff, anp5_ff, anq5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         adet5_ff <= adet_ff;
         anp5_ff  <= anp_ff;
         anq5_ff  <= anq_ff;
         tag5_ff  <= {px4_ff, py4_ff, rx4_ff, ry4_ff,
                      dzero_ff || (adet_ff < XW'(det_min_ff)),
                      sgn_ok_p_ff && (anp_ff < adet_ff),
                      sgn_ok_q_ff && (anq_ff < adet_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   logic          dv;
   logic [AB-1:0] qp, qq;
   logic [TW-1:0] dtag;

   segi_div #(.XW(XW), .AB(AB), .TW(TW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v5_ff),
      .in_num_p (anp5_ff),
      .in_num_q (anq5_ff),
      .in_den   (adet5_ff),
      .in_tag   (tag5_ff),
      .out_valid(dv),
      .out_quo_p(qp),
      .out_quo_q(qq),
      .out_tag  (dtag)
   );

   // margin test on the truncated fractions
   logic                 pass_p, pass_q;
   logic signed [CB-1:0] dpx, dpy;
   logic signed [DW-1:0] drx, dry;
   logic                 dpar, dokp, dokq;

   assign {dpx, dpy, drx, dry, dpar, dokp, dokq} = dtag;
   assign pass_p = ({1'b0, 32'(qp)} > 33'(margin_ff)) &&
                   ((33'(qp) + 33'(margin_ff)) < (33'd1 << AB));
   assign pass_q = ({1'b0, 32'(qq)} > 33'(margin_ff)) &&
                   ((33'(qq) + 33'(margin_ff)) < (33'd1 << AB));

   logic                 v6_ff;
   logic [1:0]           st6_ff;
   logic [AB-1:0]        qp6_ff, qq6_ff;
   logic signed [CB-1:0] px6_ff, py6_ff;
   logic signed [DW-1:0] rx6_ff, ry6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         qp6_ff <= qp;
         qq6_ff <= qq;
         px6_ff <= dpx;
         py6_ff <= dpy;
         rx6_ff <= drx;
         ry6_ff <= dry;
         if (dpar) begin
            st6_ff <= ST_PARALLEL;
         end else if (dokp && dokq && pass_p && pass_q) begin
            st6_ff <= ST_HIT;
         end else begin
            st6_ff <= ST_MISS;
         end
      end
   end

   // stage 7: step along the first segment
   logic                 v7_ff;
   logic [1:0]           st7_ff;
   logic [AB-1:0]        qp7_ff, qq7_ff;
   logic signed [CB-1:0] px7_ff, py7_ff;
   logic signed [MW-1:0] mx_ff, my_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         st7_ff <= st6_ff;
         qp7_ff <= qp6_ff;
         qq7_ff <= qq6_ff;
         px7_ff <= px6_ff;
         py7_ff <= py6_ff;
         mx_ff  <= MW'(signed'({1'b0, qp6_ff})) * MW'(rx6_ff);
         my_ff  <= MW'(signed'({1'b0, qp6_ff})) * MW'(ry6_ff);
      end
   end

   // output word, zeros unless a proper hit
   logic                 rsp_valid_ff;
   rsp_word_type         rsp_word_ff;
   logic signed [MW-1:0] shx, shy;

   assign shx = mx_ff >>> AB;
   assign shy = my_ff >>> AB;

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_word_ff.status <= st7_ff;
         if (st7_ff == ST_HIT) begin
            rsp_word_ff.hit_x   <= 32'(px7_ff) + 32'(shx);
            rsp_word_ff.hit_y   <= 32'(py7_ff) + 32'(shy);
            rsp_word_ff.alpha_p <= 32'(qp7_ff);
            rsp_word_ff.alpha_q <= 32'(qq7_ff);
         end else begin
            rsp_word_ff.hit_x   <= '0;
            rsp_word_ff.hit_y   <= '0;
            rsp_word_ff.alpha_p <= '0;
            rsp_word_ff.alpha_q <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v6_ff        <= dv;
         v7_ff        <= v6_ff;
         rsp_valid_ff <= v7_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef ASSERT_OFF
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_HIT |->
         rsp_word.hit_x == '0 && rsp_word.hit_y == '0 &&
         rsp_word.alpha_p == '0 && rsp_word.alpha_q == '0)
      else $error("non-hit word carries data");
   a_hit_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_HIT |->
         rsp_word.alpha_p != '0 && rsp_word.alpha_q != '0)
      else $error("hit with zero parameter");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.status == ST_HIT || rsp_word.status == ST_PARALLEL ||
                    rsp_word.status == ST_MISS)
      else $error("bad status code");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(v7_ff) && $stable(st7_ff))
      else $error("pipeline moved during stall");
`endif

endmodule

>>> bench/tb_segment_intersection.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_intersection
// Self-checking bench for the segment intersection pipeline: a directed table
// of segment pairs, then random pairs under several register settings, with
// both handshakes throttled at random except in the last two settings; every word
// is checked field by field against a table entry or a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_segment_intersection;
   import segi_pkg::*;

   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
   localparam int PHASE_PAIRS = 80;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      req_word_type pair;
      bit           typed;
      rsp_word_type want;
   } table_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_word_type         req_word = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_word_type         rsp_word;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DET_MIN;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // register shadows
   logic [DET_MIN_W-1:0] det_limit = DET_MIN_RST;
   logic [MARGIN_W-1:0]  end_margin = MARGIN_RST;

   rsp_word_type  hit_queue[$];
   table_row_type stim_table[$];
   int            send_idle = 25;
   int            recv_idle = 65;
   int            failures = 0;
   int            words_seen = 0;
   int            hits_seen = 0;
   int            parallel_seen = 0;

   segment_intersection u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // truncated Q0.32 fraction num/den, valid only strictly inside (0, 1)
   function automatic bit unit_ratio(input logic signed [127:0] num,
                                     input logic signed [127:0] den,
                                     output logic [31:0] quot);
      logic [127:0] n_mag;
      logic [127:0] d_mag;
      logic [127:0] q_full;
      quot = '0;
      if (num == 0 || den == 0 || ((num < 0) != (den < 0))) return 1'b0;
      n_mag = (num < 0) ? -num : num;
      d_mag = (den < 0) ? -den : den;
      if (n_mag >= d_mag) return 1'b0;
      q_full = (n_mag << 32) / d_mag;
      quot = q_full[31:0];
      return 1'b1;
   endfunction

   function automatic bit clear_of_ends(input logic [31:0] a);
      logic [63:0] upper;
      upper = {32'd0, a} + {33'd0, end_margin};
      return ({1'b0, a} > {1'b0, end_margin}) && (upper < 64'h1_0000_0000);
   endfunction

   function automatic logic [31:0] point_along(input logic signed [127:0] start,
                                               input logic [31:0] a,
                                               input logic signed [127:0] dir);
      logic signed [127:0] prod;
      prod = $signed({96'd0, a}) * dir;
      prod = start + (prod >>> 32);
      return prod[31:0];
   endfunction

   function automatic rsp_word_type predict_crossing(input req_word_type w);
      logic signed [127:0] px, py, rx, ry, qx, qy, sx, sy, wx, wy, det;
      logic [127:0]        det_mag;
      logic [31:0]         ap, aq;
      bit                  okp, okq;
      rsp_word_type        r;
      r = '0;
      px = w.p1_x;
      py = w.p1_y;
      qx = w.q1_x;
      qy = w.q1_y;
      rx = $signed(w.p2_x) - px;
      ry = $signed(w.p2_y) - py;
      sx = $signed(w.q2_x) - qx;
      sy = $signed(w.q2_y) - qy;
      wx = qx - px;
      wy = qy - py;
      det = rx * sy - ry * sx;
      det_mag = (det < 0) ? -det : det;
      if (det == 0 || det_mag < {65'd0, det_limit}) begin
         r.status = ST_PARALLEL;
         return r;
      end
      okp = unit_ratio(wx * sy - wy * sx, det, ap);
      okq = unit_ratio(wx * ry - wy * rx, det, aq);
      if (!(okp && okq && clear_of_ends(ap) && clear_of_ends(aq))) begin
         r.status = ST_MISS;
         return r;
      end
      r.status = ST_HIT;
      r.hit_x = point_along(px, ap, rx);
      r.hit_y = point_along(py, ap, ry);
      r.alpha_p = ap;
      r.alpha_q = aq;
      return r;
   endfunction

   function automatic req_word_type make_pair(input logic [31:0] a, b, c, d,
                                              input logic [31:0] e, f, g, h);
      req_word_type w;
      w = {a, b, c, d, e, f, g, h};
      return w;
   endfunction

   function automatic logic [31:0] coord_in(input int bits);
      logic [31:0] v;
      v = $urandom;
      if (bits >= 32) return v;
      return 32'($signed(v) >>> (32 - bits));
   endfunction

   // mostly crossing pairs with random content, some parallel, some noise
   function automatic req_word_type random_pair();
      req_word_type w;
      logic [31:0]  mx, my, vx, vy, ox, oy;
      int           kind;
      int           span;
      kind = $urandom_range(99);
      span = $urandom_range(12, 30);
      w.p1_x = coord_in(span);
      w.p1_y = coord_in(span);
      w.p2_x = coord_in(span);
      w.p2_y = coord_in(span);
      if (kind < 55) begin
         // second segment straddles the middle of the first
         mx = 32'(($signed(w.p1_x) + $signed(w.p2_x)) >>> 1);
         my = 32'(($signed(w.p1_y) + $signed(w.p2_y)) >>> 1);
         vx = coord_in(span);
         vy = coord_in(span);
         w.q1_x = mx + vx;
         w.q1_y = my + vy;
         w.q2_x = mx - vx + coord_in(span - 6);
         w.q2_y = my - vy + coord_in(span - 6);
      end else if (kind < 70) begin
         ox = coord_in(span);
         oy = coord_in(span);
         w.q1_x = w.p1_x + ox;
         w.q1_y = w.p1_y + oy;
         w.q2_x = w.p2_x + ox;
         w.q2_y = w.p2_y + oy;
      end else if (kind < 85) begin
         w = make_pair($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
      end else begin
         w.q1_x = coord_in(span);
         w.q1_y = coord_in(span);
         w.q2_x = coord_in(span);
         w.q2_y = coord_in(span);
      end
      return w;
   endfunction

   task automatic add_row(input req_word_type pair, input bit typed,
                          input rsp_word_type want);
      table_row_type row;
      row.pair = pair;
      row.typed = typed;
      row.want = want;
      stim_table = {stim_table, row};
   endtask

   task automatic send_pair(input req_word_type w, input rsp_word_type want);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      hit_queue = {hit_queue, want};
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DET_MIN) det_limit = value[DET_MIN_W-1:0];
      else end_margin = value[MARGIN_W-1:0];
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (rsp_word.status == ST_HIT) hits_seen++;
         if (rsp_word.status == ST_PARALLEL) parallel_seen++;
         if (hit_queue.size() == 0) begin
            failures++;
            $display("%0t: unexpected word %h", $time, rsp_word);
         end else begin
            want = hit_queue.pop_front();
            if (rsp_word.status !== want.status) begin
               failures++;
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_word.status);
            end
            if (rsp_word.hit_x !== want.hit_x) begin
               failures++;
               $display("%0t: hit_x expected %h actual %h", $time, want.hit_x,
                        rsp_word.hit_x);
            end
            if (rsp_word.hit_y !== want.hit_y) begin
               failures++;
               $display("%0t: hit_y expected %h actual %h", $time, want.hit_y,
                        rsp_word.hit_y);
            end
            if (rsp_word.alpha_p !== want.alpha_p) begin
               failures++;
               $display("%0t: alpha_p expected %h actual %h", $time, want.alpha_p,
                        rsp_word.alpha_p);
            end
            if (rsp_word.alpha_q !== want.alpha_q) begin
               failures++;
               $display("%0t: alpha_q expected %h actual %h", $time, want.alpha_q,
                        rsp_word.alpha_q);
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d words outstanding", hit_queue.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      rsp_word_type parallel_word;
      rsp_word_type miss_word;
      rsp_word_type x_word;
      logic [62:0]  det_set[5];
      logic [30:0]  margin_set[5];
      parallel_word = '0;
      parallel_word.status = ST_PARALLEL;
      miss_word = '0;
      miss_word.status = ST_MISS;
      x_word = '{ST_HIT, ONE_Q16, ONE_Q16, 32'h8000_0000, 32'h8000_0000};

      add_row('0, 1'b1, parallel_word);
      add_row({8{32'h7fff_ffff}}, 1'b1, parallel_word);
      add_row({8{32'h8000_0000}}, 1'b1, parallel_word);
      add_row(make_pair(0, 0, 2 * ONE_Q16, 2 * ONE_Q16,
                        0, 2 * ONE_Q16, 2 * ONE_Q16, 0), 1'b1, x_word);
      // crossing beyond the end of the first segment
      add_row(make_pair(0, 0, ONE_Q16, 0, 2 * ONE_Q16, -ONE_Q16,
                        2 * ONE_Q16, ONE_Q16), 1'b1, miss_word);
      // shared start point
      add_row(make_pair(0, 0, 2 * ONE_Q16, 0, 0, 0, 0, 2 * ONE_Q16),
              1'b1, miss_word);
      // second segment ends exactly on the first
      add_row(make_pair(0, 0, 2 * ONE_Q16, 0, ONE_Q16, -2 * ONE_Q16,
                        ONE_Q16, 0), 1'b1, miss_word);
      add_row(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h8000_0000), 1'b0, '0);
      add_row(make_pair(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7ffe_ffff), 1'b0, '0);
      // negative coordinates, point rounds toward minus infinity
      add_row(make_pair(-3 * ONE_Q16, -ONE_Q16, 0, 2 * ONE_Q16 + 1,
                        -2 * ONE_Q16, 3 * ONE_Q16, -ONE_Q16,
                        -5 * ONE_Q16 - 3), 1'b0, '0);
      // tiny determinant in raw units
      add_row(make_pair(0, 0, 3, 0, 1, -1, 2, 1), 1'b0, '0);
      add_row(make_pair(0, 0, 32'h4000_0000, 0, 1, -1, 1, 32'h4000_0000),
              1'b0, '0);
      add_row(make_pair(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555,
                        32'haaaa_aaaa, 32'haaaa_aaaa, 32'haaaa_aaaa,
                        32'h5555_5555, 32'h5555_5555), 1'b0, '0);
      add_row(make_pair(32'hffff_ffff, 32'hffff_ffff, 1, 1, 1,
                        32'hffff_ffff, 32'hffff_ffff, 1), 1'b0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i])
         send_pair(stim_table[i].pair,
                   stim_table[i].typed ? stim_table[i].want
                                       : predict_crossing(stim_table[i].pair));
      drain_pipe();

      det_set = '{63'd1, 63'd0, 63'h7fff_ffff_ffff_ffff, 63'd1 << 40, 63'd0};
      margin_set = '{31'd4, 31'd0, 31'h7fff_ffff, 31'd1 << 20, 31'd0};
      det_set[4] = 63'({4'($urandom_range(15)), 32'($urandom)});
      margin_set[4] = 31'($urandom_range(65535));
      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 1 || ph == 3) begin
            send_idle = (ph == 1) ? 65 : 0;
            recv_idle = (ph == 1) ? 25 : 0;
         end
         write_csr(CSR_DET_MIN, det_set[ph]);
         write_csr(CSR_ALPHA_MARGIN, {32'd0, margin_set[ph]});
         for (int n = 0; n < PHASE_PAIRS; n++) begin
            req_word_type w;
            w = random_pair();
            send_pair(w, predict_crossing(w));
            // hold off until the pipe is empty once
            if (ph == 2 && n == PHASE_PAIRS / 2) drain_pipe();
         end
         drain_pipe();
      end

      $display("checked %0d words: %0d hits, %0d parallel, rest misses", words_seen,
               hits_seen, parallel_seen);
      $display("five register settings incl. both extremes, three throttle patterns");
      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
